@@ rtl/core/drrip_pkg.sv @@
// shared types and constants of the drrip replacement block
package drrip_pkg;

    // fixed field widths
    localparam int SET_IN_W = 11;
    localparam int WAY_IN_W = 4;
    localparam int BLK_W    = 32;
    localparam int TALLY_W  = 24;
    localparam int LFSR_W   = 16;
    localparam int BIM_W    = 4;
    localparam int DEC_W    = 5;
    localparam int CFG_D_W  = 5;
    localparam int EPOCH_W  = 8;

    localparam logic [1:0]        RRPV_MAX   = 2'd3;
    localparam logic [1:0]        RRPV_LONG  = 2'd2;
    localparam logic [1:0]        RRPV_NEAR  = 2'd0;
    localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;
    localparam logic [BIM_W-1:0]  BIM_RESET  = 4'd5;
    localparam logic [DEC_W-1:0]  DEC_RESET  = 5'd12;
    localparam logic [DEC_W-1:0]  DEC_MIN    = 5'd1;
    localparam logic [DEC_W-1:0]  DEC_MAX    = 5'd24;

    // opcodes
    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // configuration register indexes
    localparam logic CFG_BIMODAL = 1'b0;
    localparam logic CFG_DECAY   = 1'b1;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SCRUB
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // input transfer, issue row reads
        logic exec;       // modify and write back, post result
        logic sweep;      // sweep one row
        logic sweep_main; // sweep also resets the main row
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // result slot can take a result
        logic sweep_last; // sweep counter at final row
        logic scrub_req;  // epoch wraps with this operation
    } t_status;

endpackage

@@ rtl/core/drrip_if.sv @@
// request, response and configuration channel interfaces

interface drrip_req_if;
    import drrip_pkg::*;
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way_index;
    logic [BLK_W-1:0]    block_address;
    logic                was_hit;
    modport source (output valid, opcode, set_index, way_index, block_address, was_hit,
                    input ready);
    modport sink   (input valid, opcode, set_index, way_index, block_address, was_hit,
                    output ready);
endinterface

interface drrip_rsp_if;
    import drrip_pkg::*;
    logic                valid;
    logic                ready;
    logic [WAY_IN_W-1:0] victim_way;
    logic                set_streaming;
    modport source (output valid, victim_way, set_streaming, input ready);
    modport sink   (input valid, victim_way, set_streaming, output ready);
endinterface

interface drrip_cfg_if;
    import drrip_pkg::*;
    logic               valid;
    logic               ready;
    logic               index;
    logic [CFG_D_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/drrip_ctrl.sv @@
// sequencing controller: init sweep, accept, execute, dead-bit scrub
module drrip_ctrl import drrip_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_status i_status,
    output logic    o_req_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_status.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.out_free) begin
                    n_state = i_status.scrub_req ? S_SCRUB : S_IDLE;
                end
            end
            S_SCRUB: begin
                if (i_status.sweep_last) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready      = 1'b0;
        o_cmd            = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep      = 1'b1;
                o_cmd.sweep_main = 1'b1;
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_EXEC: begin
                o_cmd.exec = i_status.out_free;
            end
            S_SCRUB: begin
                o_cmd.sweep = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/drrip_dp.sv @@
// datapath: set row memories, victim search, update logic, global counters
module drrip_dp import drrip_pkg::*; #(
    parameter int NUM_SETS       = 2048,
    parameter int NUM_WAYS       = 16,
    parameter int LEADER_SPACING = 64,
    parameter int DUEL_WIDTH     = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_status       o_status,
    drrip_req_if.sink     i_req,
    drrip_rsp_if.source   o_rsp,
    drrip_cfg_if.sink     i_cfg
);

    localparam int SW     = $clog2(NUM_SETS);
    localparam int WW     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int MAIN_W = 1 + BLK_W + 2 * NUM_WAYS;
    localparam int DEAD_W = EPOCH_W + NUM_WAYS;
    localparam int QP_W   = SW + 33;
    localparam logic [63:0] RECIP = ((64'd1 << 32) + 64'(LEADER_SPACING) - 64'd1)
                                    / 64'(LEADER_SPACING);
    localparam logic [DUEL_WIDTH-1:0] PSEL_MID = DUEL_WIDTH'(1) << (DUEL_WIDTH - 1);
    localparam logic [DUEL_WIDTH-1:0] PSEL_TOP = {DUEL_WIDTH{1'b1}};

    // memories, one row per set
    logic [MAIN_W-1:0] r_main_mem [NUM_SETS];
    logic [DEAD_W-1:0] r_dead_mem [NUM_SETS];

    logic [MAIN_W-1:0]     r_main_rd;
    logic [DEAD_W-1:0]     r_dead_rd;
    logic                  r_op;
    logic [SW-1:0]         r_set;
    logic [WW-1:0]         r_way;
    logic [BLK_W-1:0]      r_blk;
    logic                  r_hit;
    logic [SW-1:0]         r_q;
    logic [SW-1:0]         r_swp;
    logic [EPOCH_W-1:0]    r_epoch, n_epoch;
    logic [DUEL_WIDTH-1:0] r_psel, n_psel;
    logic [TALLY_W-1:0]    r_tally, n_tally;
    logic [LFSR_W-1:0]     r_lfsr, n_lfsr;
    logic [BIM_W-1:0]      r_bim;
    logic [DEC_W-1:0]      r_dec;
    logic                  r_out_valid;
    logic [WAY_IN_W-1:0]   r_victim;
    logic                  r_stream;

    logic [SW-1:0]         w_set_in;
    logic [QP_W-1:0]       w_qprod;

    // set index of the request and quotient for the leader test
    assign w_set_in = SW'(32'(i_req.set_index) % NUM_SETS);
    assign w_qprod  = QP_W'(w_set_in) * QP_W'(RECIP[32:0]);

    // configuration writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bim <= BIM_RESET;
            r_dec <= DEC_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_BIMODAL: r_bim <= i_cfg.data[BIM_W-1:0];
                CFG_DECAY:   r_dec <= i_cfg.data;
                default:     r_bim <= r_bim;
            endcase
        end
    end

    // row unpack
    logic [1:0]          w_rr   [NUM_WAYS];
    logic [NUM_WAYS-1:0] w_dead;
    logic                w_stream_old;
    logic [BLK_W-1:0]    w_prev;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_rr[w] = r_main_rd[2*w +: 2];
        end
        w_prev       = r_main_rd[2*NUM_WAYS +: BLK_W];
        w_stream_old = r_main_rd[MAIN_W-1];
        w_dead = (r_dead_rd[NUM_WAYS +: EPOCH_W] == r_epoch) ? r_dead_rd[NUM_WAYS-1:0] : '0;
    end

    // victim search with ageing
    logic [1:0]          w_top, w_add;
    logic [NUM_WAYS-1:0] w_cand, w_attop;
    logic                w_dead_pick;
    logic [WW-1:0]       w_dead_way, w_top_way;
    logic [2*NUM_WAYS-1:0] w_aged;

    always_comb begin
        w_top = 2'd0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (w_rr[w] > w_top) w_top = w_rr[w];
            w_cand[w]  = w_dead[w] && (w_rr[w] == RRPV_MAX);
            w_attop[w] = (w_rr[w] == w_top);
        end
        w_add = RRPV_MAX - w_top;
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_attop[w]       = (w_rr[w] == w_top);
            w_aged[2*w +: 2] = w_rr[w] + w_add;
        end
        w_dead_way = '0;
        w_top_way  = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (w_cand[w])  w_dead_way = WW'(w);
            if (w_attop[w]) w_top_way  = WW'(w);
        end
        w_dead_pick = w_stream_old && (|w_cand);
    end

    // stream detector and leader test
    logic [BLK_W-1:0] w_delta;
    logic             w_stream_new;
    logic [SW-1:0]    w_rem;
    logic             w_lead0, w_lead1;

    always_comb begin
        w_delta = r_blk - w_prev;
        w_stream_new = w_stream_old;
        if (w_prev != '0) begin
            if (w_delta == BLK_W'(1) || w_delta == {BLK_W{1'b1}}) begin
                w_stream_new = 1'b1;
            end else if (w_delta != '0) begin
                w_stream_new = 1'b0;
            end
        end
        w_rem   = r_set - SW'(32'(r_q) * LEADER_SPACING);
        w_lead0 = (w_rem == SW'(0));
        w_lead1 = (w_rem == SW'(1));
    end

    // insertion choice, duel counter, miss tally
    logic [LFSR_W-1:0]  w_lfsr_nx, w_bmask;
    logic               w_use_brrip;
    logic [1:0]         w_brrip, w_ins;
    logic [DEC_W-1:0]   w_lg;
    logic [TALLY_W-1:0] w_tmask, w_tally_nx;
    logic               w_clear;
    logic               w_upd;

    always_comb begin
        w_upd     = i_cmd.exec && (r_op == OP_UPDATE);
        w_lfsr_nx = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[LFSR_W-1:1]};
        w_bmask   = (LFSR_W'(1) << r_bim) - LFSR_W'(1);
        w_brrip   = ((w_lfsr_nx & w_bmask) == '0) ? RRPV_LONG : RRPV_MAX;
        w_use_brrip = !r_hit && (w_lead1 || (!w_lead0 && r_psel < PSEL_MID));
        if (w_stream_new)                  w_ins = RRPV_MAX;
        else if (w_lead0)                  w_ins = RRPV_LONG;
        else if (w_lead1)                  w_ins = w_brrip;
        else if (r_psel >= PSEL_MID)       w_ins = RRPV_LONG;
        else                               w_ins = w_brrip;

        w_lg = r_dec;
        if (w_lg < DEC_MIN) w_lg = DEC_MIN;
        if (w_lg > DEC_MAX) w_lg = DEC_MAX;
        w_tmask    = (TALLY_W'(1) << w_lg) - TALLY_W'(1);
        w_tally_nx = r_tally + TALLY_W'(1);
        w_clear    = ((w_tally_nx & w_tmask) == '0);

        n_lfsr  = r_lfsr;
        n_psel  = r_psel;
        n_tally = r_tally;
        n_epoch = r_epoch;
        if (w_upd) begin
            if (w_use_brrip) n_lfsr = w_lfsr_nx;
            if (r_hit) begin
                if (w_lead0 && r_psel < PSEL_TOP)    n_psel = r_psel + DUEL_WIDTH'(1);
                else if (w_lead1 && r_psel != '0)    n_psel = r_psel - DUEL_WIDTH'(1);
            end else begin
                n_tally = w_tally_nx;
                if (w_clear) n_epoch = r_epoch + EPOCH_W'(1);
            end
        end
    end

    // write-back rows
    logic [MAIN_W-1:0]   w_main_wr;
    logic [DEAD_W-1:0]   w_dead_wr;
    logic [2*NUM_WAYS-1:0] w_rr_upd;
    logic [NUM_WAYS-1:0] w_dead_upd;
    logic [WAY_IN_W-1:0] w_victim;

    always_comb begin
        w_rr_upd   = r_main_rd[2*NUM_WAYS-1:0];
        w_dead_upd = w_dead;
        w_rr_upd[2*r_way +: 2] = r_hit ? RRPV_NEAR : w_ins;
        w_dead_upd[r_way]      = !r_hit;
        w_victim = '0;
        if (i_cmd.sweep) begin
            w_main_wr = {1'b0, {BLK_W{1'b0}}, {NUM_WAYS{RRPV_MAX}}};
            w_dead_wr = {r_epoch, {NUM_WAYS{1'b0}}};
        end else if (r_op == OP_VICTIM) begin
            w_main_wr = w_dead_pick ? r_main_rd : {w_stream_old, w_prev, w_aged};
            w_dead_wr = r_dead_rd;
            w_victim  = WAY_IN_W'(w_dead_pick ? w_dead_way : w_top_way);
        end else begin
            w_main_wr = {w_stream_new, r_blk, w_rr_upd};
            w_dead_wr = {r_epoch, w_dead_upd};
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if ((i_cmd.sweep && i_cmd.sweep_main) || i_cmd.exec) begin
            r_main_mem[i_cmd.sweep ? r_swp : r_set] <= w_main_wr;
        end
        if (i_cmd.sweep || w_upd) begin
            r_dead_mem[i_cmd.sweep ? r_swp : r_set] <= w_dead_wr;
        end
        if (i_cmd.load) begin
            r_main_rd <= r_main_mem[w_set_in];
            r_dead_rd <= r_dead_mem[w_set_in];
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_req.opcode;
            r_set <= w_set_in;
            r_way <= WW'(32'(i_req.way_index) % NUM_WAYS);
            r_blk <= i_req.block_address;
            r_hit <= i_req.was_hit;
            r_q   <= w_qprod[32 +: SW];
        end
    end

    // global state and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swp   <= '0;
            r_epoch <= '0;
            r_psel  <= PSEL_MID;
            r_tally <= '0;
            r_lfsr  <= LFSR_SEED;
        end else begin
            if (i_cmd.sweep) r_swp <= r_swp + SW'(1);
            r_epoch <= n_epoch;
            r_psel  <= n_psel;
            r_tally <= n_tally;
            r_lfsr  <= n_lfsr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_victim <= w_victim;
            r_stream <= (r_op == OP_VICTIM) ? w_stream_old : w_stream_new;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.victim_way    = r_victim;
    assign o_rsp.set_streaming = r_stream;

    assign o_status.out_free   = !r_out_valid || o_rsp.ready;
    assign o_status.sweep_last = &r_swp;
    assign o_status.scrub_req  = w_upd && !r_hit && w_clear && (n_epoch == '0);

    // checks
    a_exec_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (!r_out_valid || o_rsp.ready))
        else $error("result posted into a full slot");
    a_exec_posts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("executed operation left no result");
    a_no_load_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !i_cmd.sweep && !i_cmd.exec)
        else $error("request read during sweep or execute");
    a_scrub_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && o_status.scrub_req) |=> (r_epoch == '0))
        else $error("scrub started without epoch wrap");

endmodule

@@ rtl/core/drrip_replacement_stream_dead_bits_top.sv @@
// top level of the drrip replacement block with dead bits and stream detection
//
//  channel | dir | transfer when       | contents
//  i_req   | in  | valid & ready       | opcode, set_index, way_index, block_address, was_hit
//  o_rsp   | out | valid & ready       | victim_way, set_streaming
//  i_cfg   | in  | valid (ready is 1)  | index (0 bimodal rate, 1 decay interval), data
//
//  in each operation a transfer reads the set row from the row memories; the execute step
//  then modifies the row, writes it back and loads the result register.
//  after reset a clearing pass initializes every row; no request is taken.
//  dead-bit clears advance an epoch mark; when it wraps, a scrub of the dead-bit rows runs.
//  a result waiting in the result register does not block the next request transfer;
//  the write-back cycle waits until the result register is free.
module drrip_replacement_stream_dead_bits_top import drrip_pkg::*; #(
    parameter int NUM_SETS       = 2048,
    parameter int NUM_WAYS       = 16,
    parameter int LEADER_SPACING = 64,
    parameter int DUEL_WIDTH     = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drrip_req_if.sink   i_req,
    drrip_rsp_if.source o_rsp,
    drrip_cfg_if.sink   i_cfg
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_ready;

    assign i_req.ready = w_ready;

    // sequencing
    drrip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (w_status),
        .o_req_ready (w_ready),
        .o_cmd       (w_cmd)
    );

    // replacement state and logic
    drrip_dp #(
        .NUM_SETS       (NUM_SETS),
        .NUM_WAYS       (NUM_WAYS),
        .LEADER_SPACING (LEADER_SPACING),
        .DUEL_WIDTH     (DUEL_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .i_cfg    (i_cfg)
    );

endmodule
